// ----- src/bpl_pkg.sv -----
// ----------------------------------------------------------------------------
// bpl_pkg
// shared types, codes and constants of the keypad press latch
// ----------------------------------------------------------------------------
package bpl_pkg;

    // lockout counter width, 8 to 32
    localparam int DELAY_BITS  = 32;
    localparam int CFG_WIDTH   = 32;
    localparam int NUM_BUTTONS = 5;
    localparam int BTN_WIDTH   = 3;

    localparam logic [CFG_WIDTH-1:0] DELAY_RESET = 32'd300000;

    // largest counter value, one bit wider than the register
    localparam logic [CFG_WIDTH:0] CNT_MAX =
        (33'd1 << DELAY_BITS) - 33'd1;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SCAN  = 2'd1;
    localparam logic [1:0] KIND_GET   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // button codes
    localparam logic [BTN_WIDTH-1:0] BTN_CENTER = 3'd0;
    localparam logic [BTN_WIDTH-1:0] BTN_LEFT   = 3'd4;

    typedef struct packed {
        logic [1:0]             kind;
        logic [NUM_BUTTONS-1:0] levels;   // bit0 center .. bit4 left
    } t_item;

    typedef struct packed {
        logic                   scan_skipped;
        logic [NUM_BUTTONS-1:0] held_mask;
        logic [BTN_WIDTH-1:0]   read_button;
        logic                   read_valid;
    } t_result;

endpackage

// ----- src/bpl_in_reg.sv -----
// ----------------------------------------------------------------------------
// bpl_in_reg
// input register holding one accepted item until the core takes it
// ----------------------------------------------------------------------------
module bpl_in_reg
    import bpl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- src/bpl_keypad.sv -----
// ----------------------------------------------------------------------------
// bpl_keypad
// press state, edge detect, priority pick and lockout counter
// ----------------------------------------------------------------------------
module bpl_keypad
    import bpl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_WIDTH-1:0] i_cfg_wdata,
    input  logic                 i_fire,
    input  t_item                i_item,
    output t_result              o_result
);

    logic [CFG_WIDTH-1:0]   r_delay;
    logic [NUM_BUTTONS-1:0] r_last,   n_last;
    logic                   r_pend,   n_pend;
    logic [BTN_WIDTH-1:0]   r_btn,    n_btn;
    logic                   r_active, n_active;
    logic [DELAY_BITS-1:0]  r_rem,    n_rem;

    logic                   blocking;
    logic [NUM_BUTTONS-1:0] fell;
    logic [BTN_WIDTH-1:0]   pick;
    logic [DELAY_BITS-1:0]  load_val;

    assign blocking = r_active && (r_rem != '0);
    assign fell     = (i_item.levels ^ r_last) & ~i_item.levels;
    assign load_val = ({1'b0, r_delay} > CNT_MAX) ? {DELAY_BITS{1'b1}}
                                                  : r_delay[DELAY_BITS-1:0];

    // lowest index wins
    always_comb begin
        pick = BTN_CENTER;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (fell[i]) begin
                pick = BTN_WIDTH'(i);
            end
        end
    end

    always_comb begin
        n_last   = r_last;
        n_pend   = r_pend;
        n_btn    = r_btn;
        n_active = r_active;
        n_rem    = r_rem;
        o_result = '0;
        o_result.held_mask = ~i_item.levels;
        unique case (i_item.kind)
            KIND_TICK: begin
                if (blocking) begin
                    n_rem = r_rem - 1'b1;
                end
            end
            KIND_SCAN: begin
                if (r_pend || blocking) begin
                    o_result.scan_skipped = 1'b1;
                end else begin
                    n_active = 1'b0;
                    n_rem    = '0;
                    if (fell != '0) begin
                        n_pend   = 1'b1;
                        n_btn    = pick;
                        n_active = 1'b1;
                        n_rem    = load_val;
                    end
                    n_last = i_item.levels;
                end
            end
            KIND_GET: begin
                if (r_pend) begin
                    o_result.read_valid  = 1'b1;
                    o_result.read_button = r_btn;
                end
                n_pend = 1'b0;
            end
            KIND_CLEAR: begin
                n_last = '1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DELAY_RESET;
            r_last   <= '0;
            r_pend   <= 1'b0;
            r_btn    <= BTN_CENTER;
            r_active <= 1'b0;
            r_rem    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_delay <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_last   <= n_last;
                r_pend   <= n_pend;
                r_btn    <= n_btn;
                r_active <= n_active;
                r_rem    <= n_rem;
            end
        end
    end

endmodule

// ----- src/bpl_out_reg.sv -----
// ----------------------------------------------------------------------------
// bpl_out_reg
// result register, holds a result until the downstream side takes it
// ----------------------------------------------------------------------------
module bpl_out_reg
    import bpl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- src/button_press_latch_lockout_core.sv -----
// ----------------------------------------------------------------------------
// button_press_latch_lockout_core
// five-button keypad front end: press latch, held mask and repeat lockout
// ----------------------------------------------------------------------------
// path: each item is held in the input register, then its result in the result
//   register, from which the result transfer is made
// throughput: one item per cycle unless m_axis_tready stalls, both registers advance together
// reset: synchronous active low; delay register returns to 300000, press
//   state, stored levels and lockout counter clear, no clearing pass
// ----------------------------------------------------------------------------
module button_press_latch_lockout_core
    import bpl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: button_delay
    input  logic                 i_cfg_we,
    input  logic [CFG_WIDTH-1:0] i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // center, up, down, right, left, zero pad
    input  logic [1:0]           s_axis_tuser,  // kind
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata   // read_valid, read_button[3], held_mask[5],
                                                // scan_skipped, zero pad
);

    t_item   in_item;
    t_item   stage_item;
    t_result core_result;
    t_result out_result;
    logic    stage_valid;
    logic    out_space;
    logic    w_adv;

    assign in_item.kind   = s_axis_tuser;
    assign in_item.levels = s_axis_tdata[NUM_BUTTONS-1:0];

    // an item moves from the input register to the result register
    // whenever the result register has room; state commits on that move
    assign w_adv = stage_valid && out_space;

    bpl_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (w_adv),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    // decision logic and press state
    bpl_keypad u_keypad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_adv),
        .i_item      (stage_item),
        .o_result    (core_result)
    );

    bpl_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_space  (out_space),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    // packed result, lowest field first
    assign m_axis_tdata = {6'd0, out_result};

    // every item that leaves the input register shows up as a result
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> m_axis_tvalid)
        else $error("advanced item did not reach result register");

    // a delivered press and a skipped scan never come from one item
    a_valid_skip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[9])
        else $error("read_valid and scan_skipped both set");

    // no press delivered means button field is zero, else a legal code
    a_button_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] ? (m_axis_tdata[3:1] <= BTN_LEFT)
                                           : (m_axis_tdata[3:1] == BTN_CENTER)))
        else $error("bad read_button value");

endmodule
